// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// NMA_ASSERT checks a property while reset is low; NMA_ASSERT_NR checks it at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NMA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("nma assertion failed");
`define NMA_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("nma assertion failed");
`else
`define NMA_ASSERT(label, clk, rst, prop)
`define NMA_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== design/nma_pkg.sv =====
package nma_pkg;

   // Default number of fraction bits of the fixed point format
   localparam int FRAC_BITS_DEF = 8;

   localparam int DATA_W    = 16;
   localparam int ACC_W     = 40;
   localparam int CSR_IDX_W = 2;
   localparam int DEN_W     = 33;
   localparam int SER_TERMS = 20;
   localparam int SQ_STEPS  = 5;

   // Activation select codes
   localparam logic [2:0] ACT_RELU     = 3'd0;
   localparam logic [2:0] ACT_SIGMOID  = 3'd1;
   localparam logic [2:0] ACT_TANH     = 3'd2;
   localparam logic [2:0] ACT_IDENTITY = 3'd3;
   localparam logic [2:0] ACT_BIAS     = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_SELECT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMOID_SCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TANH_SCALE    = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] term_weight;
      logic signed [DATA_W-1:0] source_value;
      logic signed [DATA_W-1:0] start_value;
      logic                     first;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] activated_value;
      logic signed [DATA_W-1:0] slope;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ROUND,
      ST_SIMPLE,
      ST_ARG_MUL,
      ST_ARG,
      ST_SER_MUL,
      ST_SER_DIV,
      ST_SER_WAIT,
      ST_SQ_PREP,
      ST_SQ_MUL,
      ST_SQ_UPD,
      ST_QUOT_DIV,
      ST_QUOT_WAIT,
      ST_SLOPE_A,
      ST_SLOPE_B,
      ST_SLOPE_C,
      ST_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_MAC,
      OP_ROUND,
      OP_SIMPLE,
      OP_ARG_MUL,
      OP_ARG,
      OP_SER_MUL,
      OP_SER_DIV,
      OP_SER_ACC,
      OP_SQ_PREP,
      OP_SQ_MUL,
      OP_SQ_UPD,
      OP_QUOT_DIV,
      OP_QUOT_Y,
      OP_SLOPE_A,
      OP_SLOPE_B,
      OP_SLOPE_C,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic curve;
      logic arg_zero;
      logic div_done;
      logic ser_last;
      logic sq_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== design/nma_div.sv =====
module nma_div #(
   parameter int NUM_W = nma_pkg::FRAC_BITS_DEF + 32,
   parameter int DEN_W = nma_pkg::DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [NUM_W-1:0] quotient,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // One restoring step per cycle, quotient bits shift in at the bottom
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== design/nma_ctrl.sv =====
`include "assert_macros.svh"

module nma_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_stall,
   input  nma_pkg::dp_status_type status,
   output nma_pkg::dp_op_type     dp_op
);

   nma_pkg::state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nma_pkg::ST_IDLE: begin
            if (req_valid && req_last) state_in = nma_pkg::ST_ROUND;
         end
         nma_pkg::ST_ROUND: begin
            state_in = status.curve ? nma_pkg::ST_ARG_MUL : nma_pkg::ST_SIMPLE;
         end
         nma_pkg::ST_SIMPLE:  state_in = nma_pkg::ST_EMIT;
         nma_pkg::ST_ARG_MUL: state_in = nma_pkg::ST_ARG;
         nma_pkg::ST_ARG: begin
            state_in = status.arg_zero ? nma_pkg::ST_QUOT_DIV : nma_pkg::ST_SER_MUL;
         end
         nma_pkg::ST_SER_MUL: state_in = nma_pkg::ST_SER_DIV;
         nma_pkg::ST_SER_DIV: state_in = nma_pkg::ST_SER_WAIT;
         nma_pkg::ST_SER_WAIT: begin
            if (status.div_done) begin
               state_in = status.ser_last ? nma_pkg::ST_SQ_PREP : nma_pkg::ST_SER_MUL;
            end
         end
         nma_pkg::ST_SQ_PREP: state_in = nma_pkg::ST_SQ_MUL;
         nma_pkg::ST_SQ_MUL:  state_in = nma_pkg::ST_SQ_UPD;
         nma_pkg::ST_SQ_UPD: begin
            state_in = status.sq_last ? nma_pkg::ST_QUOT_DIV : nma_pkg::ST_SQ_MUL;
         end
         nma_pkg::ST_QUOT_DIV: state_in = nma_pkg::ST_QUOT_WAIT;
         nma_pkg::ST_QUOT_WAIT: begin
            if (status.div_done) state_in = nma_pkg::ST_SLOPE_A;
         end
         nma_pkg::ST_SLOPE_A: state_in = nma_pkg::ST_SLOPE_B;
         nma_pkg::ST_SLOPE_B: state_in = nma_pkg::ST_SLOPE_C;
         nma_pkg::ST_SLOPE_C: state_in = nma_pkg::ST_EMIT;
         nma_pkg::ST_EMIT: begin
            if (status.out_free) state_in = nma_pkg::ST_IDLE;
         end
         default: state_in = nma_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      req_stall = (state_ff != nma_pkg::ST_IDLE);
      dp_op     = nma_pkg::OP_NONE;
      unique case (state_ff)
         nma_pkg::ST_IDLE:     dp_op = req_valid ? nma_pkg::OP_MAC : nma_pkg::OP_NONE;
         nma_pkg::ST_ROUND:    dp_op = nma_pkg::OP_ROUND;
         nma_pkg::ST_SIMPLE:   dp_op = nma_pkg::OP_SIMPLE;
         nma_pkg::ST_ARG_MUL:  dp_op = nma_pkg::OP_ARG_MUL;
         nma_pkg::ST_ARG:      dp_op = nma_pkg::OP_ARG;
         nma_pkg::ST_SER_MUL:  dp_op = nma_pkg::OP_SER_MUL;
         nma_pkg::ST_SER_DIV:  dp_op = nma_pkg::OP_SER_DIV;
         nma_pkg::ST_SER_WAIT: begin
            dp_op = status.div_done ? nma_pkg::OP_SER_ACC : nma_pkg::OP_NONE;
         end
         nma_pkg::ST_SQ_PREP:  dp_op = nma_pkg::OP_SQ_PREP;
         nma_pkg::ST_SQ_MUL:   dp_op = nma_pkg::OP_SQ_MUL;
         nma_pkg::ST_SQ_UPD:   dp_op = nma_pkg::OP_SQ_UPD;
         nma_pkg::ST_QUOT_DIV: dp_op = nma_pkg::OP_QUOT_DIV;
         nma_pkg::ST_QUOT_WAIT: begin
            dp_op = status.div_done ? nma_pkg::OP_QUOT_Y : nma_pkg::OP_NONE;
         end
         nma_pkg::ST_SLOPE_A:  dp_op = nma_pkg::OP_SLOPE_A;
         nma_pkg::ST_SLOPE_B:  dp_op = nma_pkg::OP_SLOPE_B;
         nma_pkg::ST_SLOPE_C:  dp_op = nma_pkg::OP_SLOPE_C;
         nma_pkg::ST_EMIT: begin
            dp_op = status.out_free ? nma_pkg::OP_EMIT : nma_pkg::OP_NONE;
         end
         default:              dp_op = nma_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Reset returns the sequencer to idle
   `NMA_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == nma_pkg::ST_IDLE))
   // Divider completion only shows up while a wait state expects it
   `NMA_ASSERT(a_div_done_wait, clock, reset,
      status.div_done |-> (state_ff == nma_pkg::ST_SER_WAIT ||
                           state_ff == nma_pkg::ST_QUOT_WAIT))
   // A closing term always starts the rounding step
   `NMA_ASSERT(a_last_rounds, clock, reset,
      (req_valid && !req_stall && req_last) |=> (state_ff == nma_pkg::ST_ROUND))

endmodule

// ===== design/nma_dpath.sv =====
module nma_dpath #(
   parameter int FRAC_BITS = nma_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  nma_pkg::dp_op_type              dp_op,
   output nma_pkg::dp_status_type          status,
   input  nma_pkg::req_type                req_data,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output nma_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [nma_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nma_pkg::DATA_W-1:0]      csr_wdata
);

   localparam int DW    = nma_pkg::DATA_W;
   localparam int ACC_W = nma_pkg::ACC_W;
   localparam int DEN_W = nma_pkg::DEN_W;
   localparam int NUM_W = FRAC_BITS + 32;

   localparam int SH_SIG  = 25 - 2 * FRAC_BITS;
   localparam int SH_TANH = 26 - 2 * FRAC_BITS;
   localparam int SIG_L   = (SH_SIG > 0) ? SH_SIG : 0;
   localparam int SIG_R   = (SH_SIG < 0) ? -SH_SIG : 0;
   localparam int TANH_L  = (SH_TANH > 0) ? SH_TANH : 0;
   localparam int TANH_R  = (SH_TANH < 0) ? -SH_TANH : 0;

   localparam logic [63:0] BIG_SIG    = 64'd1 << (2 * FRAC_BITS + 5);
   localparam logic [63:0] BIG_TANH   = 64'd1 << (2 * FRAC_BITS + 4);
   localparam logic [63:0] ONE_Q30_W  = 64'd1 << 30;
   localparam logic [63:0] SQ_HALF    = 64'd1 << 29;
   localparam logic [63:0] SLOPE_HALF = 64'd1 << (2 * FRAC_BITS - 1);
   localparam logic [63:0] SLOPE_MAX  = 64'd32767;
   localparam logic [30:0] ONE_Q30    = 31'd1 << 30;
   localparam logic [33:0] ONE_Q30_S  = 34'd1 << 30;
   localparam logic [31:0] ONE_SQ     = 32'd1 << (2 * FRAC_BITS);

   localparam logic signed [DW-1:0] ONE_FX  = DW'(1 << FRAC_BITS);
   localparam logic signed [DW-1:0] S16_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] S16_MIN = {1'b1, {(DW-1){1'b0}}};

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [ACC_W:0]   RND_HALF = (ACC_W + 1)'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [ACC_W:0]   RND_MAX  =
      {{(ACC_W + 1 - DW){1'b0}}, 1'b0, {(DW-1){1'b1}}};
   localparam logic signed [ACC_W:0]   RND_MIN  =
      {{(ACC_W + 1 - DW){1'b1}}, 1'b1, {(DW-1){1'b0}}};

   // Registers
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [2:0]              act_sel_ff, act_sel_in;
   logic [DW-1:0]           sig_scale_ff, sig_scale_in;
   logic [DW-1:0]           tanh_scale_ff, tanh_scale_in;
   logic signed [DW-1:0]    s_ff, s_in;
   logic [DW-1:0]           mag_ff, mag_in;
   logic [63:0]             prod_ff, prod_in;
   logic [29:0]             yarg_ff, yarg_in;
   logic [30:0]             term_ff, term_in;
   logic [33:0]             pos_ff, pos_in;
   logic [33:0]             neg_ff, neg_in;
   logic [4:0]              k_ff, k_in;
   logic [30:0]             r_ff, r_in;
   logic signed [DW-1:0]    y_ff, y_in;
   logic signed [DW-1:0]    slope_ff, slope_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   nma_pkg::rsp_type        rsp_ff, rsp_in;

   // Combinational helpers
   logic signed [2*DW-1:0]  wv;
   logic signed [ACC_W-1:0] st_ext;
   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W:0]   mac_sum;
   logic signed [ACC_W-1:0] mac_sat;
   logic signed [ACC_W:0]   rnd_sum;
   logic signed [ACC_W:0]   rnd_shift;
   logic signed [DW-1:0]    s_rnd;
   logic                    is_tanh;
   logic [DW-1:0]           scale_sel;
   logic [DW-1:0]           y_abs;
   logic [31:0]             mul_a;
   logic [31:0]             mul_b;
   logic [63:0]             arg_shift;
   logic [63:0]             arg_big;
   logic                    arg_zero;
   logic [33:0]             ser_diff;
   logic [63:0]             sq_round;
   logic [63:0]             slope_round;
   logic [31:0]             quot_d;
   logic [NUM_W-1:0]        quot_num;
   logic [DW-1:0]           quot_q;
   logic                    div_start;
   logic [NUM_W-1:0]        div_num;
   logic [DEN_W-1:0]        div_den;
   logic [NUM_W-1:0]        div_quo;
   logic                    div_done;
   logic                    out_free;

   nma_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (div_den),
      .quotient(div_quo),
      .done    (div_done)
   );

   assign is_tanh   = (act_sel_ff == nma_pkg::ACT_TANH);
   assign scale_sel = is_tanh ? tanh_scale_ff : sig_scale_ff;
   assign y_abs     = y_ff[DW-1] ? DW'(-y_ff) : y_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Term product and saturating accumulate
   always_comb begin
      wv      = req_data.term_weight * req_data.source_value;
      st_ext  = {{(ACC_W-DW){req_data.start_value[DW-1]}}, req_data.start_value};
      st_ext  = st_ext <<< FRAC_BITS;
      base    = req_data.first ? st_ext : acc_ff;
      mac_sum = {base[ACC_W-1], base} + {{(ACC_W+1-2*DW){wv[2*DW-1]}}, wv};
      if (mac_sum[ACC_W] != mac_sum[ACC_W-1]) begin
         mac_sat = mac_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         mac_sat = mac_sum[ACC_W-1:0];
      end
   end

   // Round to nearest and saturate the sum
   always_comb begin
      rnd_sum   = {acc_ff[ACC_W-1], acc_ff} + RND_HALF;
      rnd_shift = rnd_sum >>> FRAC_BITS;
      if (rnd_shift > RND_MAX) begin
         s_rnd = S16_MAX;
      end else if (rnd_shift < RND_MIN) begin
         s_rnd = S16_MIN;
      end else begin
         s_rnd = rnd_shift[DW-1:0];
      end
   end

   // Exponent argument in Q30 and range check
   always_comb begin
      if (is_tanh) begin
         arg_shift = (prod_ff << TANH_L) >> TANH_R;
         arg_big   = BIG_TANH;
      end else begin
         arg_shift = (prod_ff << SIG_L) >> SIG_R;
         arg_big   = BIG_SIG;
      end
      arg_zero = (prod_ff >= arg_big) || (arg_shift >= ONE_Q30_W);
   end

   // Shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (dp_op)
         nma_pkg::OP_ARG_MUL: begin
            mul_a = 32'(scale_sel);
            mul_b = 32'(mag_ff);
         end
         nma_pkg::OP_SER_MUL: begin
            mul_a = 32'(term_ff);
            mul_b = 32'(yarg_ff);
         end
         nma_pkg::OP_SQ_MUL: begin
            mul_a = 32'(r_ff);
            mul_b = 32'(r_ff);
         end
         nma_pkg::OP_SLOPE_A: begin
            if (is_tanh) begin
               mul_a = 32'(y_abs);
               mul_b = 32'(y_abs);
            end else begin
               mul_a = 32'(y_ff);
               mul_b = 32'(DW'(ONE_FX - y_ff));
            end
         end
         nma_pkg::OP_SLOPE_B: begin
            mul_a = is_tanh ? (ONE_SQ - prod_ff[31:0]) : prod_ff[31:0];
            mul_b = 32'(scale_sel);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Divider operands for the series terms and the final ratio
   always_comb begin
      quot_d = {1'b0, ONE_Q30} + {1'b0, r_ff};
      if (is_tanh) begin
         quot_num = (NUM_W'(ONE_Q30 - r_ff) << (FRAC_BITS + 1)) + NUM_W'(quot_d);
      end else if (s_ff[DW-1]) begin
         quot_num = (NUM_W'(r_ff) << (FRAC_BITS + 1)) + NUM_W'(quot_d);
      end else begin
         quot_num = (NUM_W'(1) << (FRAC_BITS + 31)) + NUM_W'(quot_d);
      end
      div_start = (dp_op == nma_pkg::OP_SER_DIV) || (dp_op == nma_pkg::OP_QUOT_DIV);
      if (dp_op == nma_pkg::OP_SER_DIV) begin
         div_num = NUM_W'(prod_ff[60:30]);
         div_den = DEN_W'(k_ff);
      end else begin
         div_num = quot_num;
         div_den = {quot_d, 1'b0};
      end
   end

   // Register updates per command
   always_comb begin
      acc_in        = acc_ff;
      act_sel_in    = act_sel_ff;
      sig_scale_in  = sig_scale_ff;
      tanh_scale_in = tanh_scale_ff;
      s_in          = s_ff;
      mag_in        = mag_ff;
      prod_in       = prod_ff;
      yarg_in       = yarg_ff;
      term_in       = term_ff;
      pos_in        = pos_ff;
      neg_in        = neg_ff;
      k_in          = k_ff;
      r_in          = r_ff;
      y_in          = y_ff;
      slope_in      = slope_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      ser_diff      = (pos_ff > neg_ff) ? (pos_ff - neg_ff) : '0;
      sq_round      = prod_ff + SQ_HALF;
      slope_round   = (prod_ff + SLOPE_HALF) >> (2 * FRAC_BITS);
      quot_q        = div_quo[DW-1:0];

      // Drop the output once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      // Configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            nma_pkg::CSR_ACT_SELECT:    act_sel_in    = csr_wdata[2:0];
            nma_pkg::CSR_SIGMOID_SCALE: sig_scale_in  = csr_wdata;
            nma_pkg::CSR_TANH_SCALE:    tanh_scale_in = csr_wdata;
            default: ;
         endcase
      end

      case (dp_op)
         nma_pkg::OP_MAC: begin
            acc_in = mac_sat;
         end
         nma_pkg::OP_ROUND: begin
            s_in   = s_rnd;
            mag_in = s_rnd[DW-1] ? DW'(-s_rnd) : s_rnd;
         end
         nma_pkg::OP_SIMPLE: begin
            unique case (act_sel_ff)
               nma_pkg::ACT_RELU: begin
                  y_in     = (s_ff > 0) ? s_ff : '0;
                  slope_in = (s_ff > 0) ? ONE_FX : '0;
               end
               nma_pkg::ACT_IDENTITY: begin
                  y_in     = s_ff;
                  slope_in = ONE_FX;
               end
               nma_pkg::ACT_BIAS: begin
                  y_in     = ONE_FX;
                  slope_in = '0;
               end
               default: begin
                  y_in     = s_ff;
                  slope_in = '0;
               end
            endcase
         end
         nma_pkg::OP_ARG_MUL, nma_pkg::OP_SER_MUL, nma_pkg::OP_SQ_MUL,
         nma_pkg::OP_SLOPE_A, nma_pkg::OP_SLOPE_B: begin
            prod_in = mul_a * mul_b;
         end
         nma_pkg::OP_ARG: begin
            yarg_in = arg_shift[29:0];
            term_in = ONE_Q30;
            pos_in  = ONE_Q30_S;
            neg_in  = '0;
            k_in    = 5'd1;
            if (arg_zero) r_in = '0;
         end
         nma_pkg::OP_SER_ACC: begin
            term_in = div_quo[30:0];
            if (k_ff[0]) begin
               neg_in = neg_ff + {3'b000, div_quo[30:0]};
            end else begin
               pos_in = pos_ff + {3'b000, div_quo[30:0]};
            end
            k_in = k_ff + 1'b1;
         end
         nma_pkg::OP_SQ_PREP: begin
            r_in = (ser_diff > ONE_Q30_S) ? ONE_Q30 : ser_diff[30:0];
            k_in = '0;
         end
         nma_pkg::OP_SQ_UPD: begin
            r_in = sq_round[60:30];
            k_in = k_ff + 1'b1;
         end
         nma_pkg::OP_QUOT_Y: begin
            y_in = (is_tanh && s_ff[DW-1]) ? DW'(-quot_q) : quot_q;
         end
         nma_pkg::OP_SLOPE_C: begin
            slope_in = (slope_round > SLOPE_MAX) ? S16_MAX : slope_round[DW-1:0];
         end
         nma_pkg::OP_EMIT: begin
            rsp_in.activated_value = y_ff;
            rsp_in.slope           = slope_ff;
            rsp_valid_in           = 1'b1;
            acc_in = {{(ACC_W-DW){y_ff[DW-1]}}, y_ff} <<< FRAC_BITS;
         end
         default: ;
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         act_sel_ff    <= nma_pkg::ACT_RELU;
         sig_scale_ff  <= DW'(1 << FRAC_BITS);
         tanh_scale_ff <= DW'(1 << FRAC_BITS);
         rsp_valid_ff  <= 1'b0;
         k_ff          <= '0;
      end else begin
         acc_ff        <= acc_in;
         act_sel_ff    <= act_sel_in;
         sig_scale_ff  <= sig_scale_in;
         tanh_scale_ff <= tanh_scale_in;
         rsp_valid_ff  <= rsp_valid_in;
         k_ff          <= k_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      yarg_ff  <= yarg_in;
      term_ff  <= term_in;
      pos_ff   <= pos_in;
      neg_ff   <= neg_in;
      r_ff     <= r_in;
      y_ff     <= y_in;
      slope_ff <= slope_in;
      rsp_ff   <= rsp_in;
   end

   // Status back to the controller
   always_comb begin
      status.curve    = (act_sel_ff == nma_pkg::ACT_SIGMOID) ||
                        (act_sel_ff == nma_pkg::ACT_TANH);
      status.arg_zero = arg_zero;
      status.div_done = div_done;
      status.ser_last = (k_ff == 5'(nma_pkg::SER_TERMS));
      status.sq_last  = (k_ff == 5'(nma_pkg::SQ_STEPS - 1));
      status.out_free = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/neuron_mac_activation_core.sv =====
// Neuron multiply-accumulate with activation.
// req channel: one connection per transfer (weight, source value, start value, first, last).
// A transfer with first set reloads the accumulator from start_value before adding its term.
// A transfer without last is accumulated and the block stays idle; the next one is taken in the following cycle.
// A transfer with last rounds the sum, applies the activation from activation_select and
// writes one rsp transfer (activated value and slope) into the output register.
// Relu, identity, bias and pass codes need no divider; sigmoid and tanh use the
// one-bit-per-cycle divider, which serves the twenty series terms and the final ratio.
// req_stall is high while a last transfer is being worked on.
// If rsp_stall holds the output register full, the block keeps taking non-last transfers
// and holds a finished result in its last step until the register frees up.
// The csr port writes activation_select, sigmoid_scale, tanh_scale by index; csr_ready is
// always high and writes to index 3 are ignored. Write registers only while idle.
// Reset clears the accumulator and output valid, selects relu and sets both scales to 1.0.
module neuron_mac_activation_core #(
   parameter int FRAC_BITS = nma_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  nma_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output nma_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [nma_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nma_pkg::DATA_W-1:0]    csr_wdata
);

   nma_pkg::dp_op_type     dp_op;
   nma_pkg::dp_status_type status;
   logic                   csr_wr_en;

   // Register writes complete on any cycle
   assign csr_ready = 1'b1;
   assign csr_wr_en = csr_valid && csr_ready;

   nma_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_last (req_data.last),
      .req_stall(req_stall),
      .status   (status),
      .dp_op    (dp_op)
   );

   nma_dpath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .dp_op    (dp_op),
      .status   (status),
      .req_data (req_data),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

endmodule
